// ===== sv/kwm_pkg.sv =====
// Shared types, sizes and helpers for the k-way merge unit.
package kwm_pkg;

  localparam int LIST_BITS    = 3;
  localparam int MAX_LISTS    = 1 << LIST_BITS;
  localparam int BUFFER_DEPTH = 8;
  localparam int VALUE_BITS   = 32;
  localparam int NL_W         = 4;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int SLOT_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int SUM_W        = $clog2(2 * BUFFER_DEPTH) + 1;
  localparam int BUF_ENTRIES  = MAX_LISTS * BUFFER_DEPTH;
  localparam int ADDR_W       = $clog2(BUF_ENTRIES);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [SLOT_W-1:0]            slot_t;
  typedef logic [LIST_BITS-1:0]         list_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [NL_W-1:0]              nlists_t;

  typedef enum logic [1:0] {
    ST_ELEM       = 2'd0,
    ST_EMPTY_DONE = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD        = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ELEM  = 1'b0,
    REQ_CLOSE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FETCH
  } state_t;

  // head selection result
  typedef struct packed {
    logic   go;
    logic   done;
    list_t  best;
    value_t best_val;
  } sel_t;

  function automatic slot_t slot_inc(input slot_t s);
    slot_t r;
    if (s == SLOT_W'(BUFFER_DEPTH - 1)) r = '0;
    else r = s + 1'b1;
    return r;
  endfunction

  // tail slot of a circular buffer
  function automatic slot_t wr_slot(input slot_t s, input cnt_t c);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(s) + SUM_W'(c);
    if (sum >= SUM_W'(BUFFER_DEPTH)) sum = sum - SUM_W'(BUFFER_DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

  function automatic addr_t buf_addr(input list_t id, input slot_t s);
    return addr_t'(ADDR_W'(id) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(s));
  endfunction

endpackage

// ===== sv/kwm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/kwm_head_sel.sv =====
// Minimum search over the cached list heads, plus emit and completion checks.
module kwm_head_sel import kwm_pkg::*; (
  input  value_t heads  [MAX_LISTS],
  input  cnt_t   counts [MAX_LISTS],
  input  logic   closed [MAX_LISTS],
  input  logic   active [MAX_LISTS],
  output sel_t   sel
);

  localparam int NODES = 2 * MAX_LISTS - 1;

  logic   nv   [NODES];
  value_t nval [NODES];
  list_t  nidx [NODES];
  logic   all_ready;
  logic   any_buf;
  logic   all_done;

  always_comb begin
    all_ready = 1'b1;
    all_done  = 1'b1;
    any_buf   = 1'b0;
    for (int i = 0; i < MAX_LISTS; i++) begin
      nv[MAX_LISTS-1+i]   = active[i] && (counts[i] != '0);
      nval[MAX_LISTS-1+i] = heads[i];
      nidx[MAX_LISTS-1+i] = LIST_BITS'(i);
      if (active[i] && counts[i] == '0 && !closed[i]) all_ready = 1'b0;
      if (active[i] && (counts[i] != '0 || !closed[i])) all_done = 1'b0;
      if (active[i] && counts[i] != '0) any_buf = 1'b1;
    end
    // balanced tree; the left side holds lower list numbers and wins ties
    for (int p = MAX_LISTS - 2; p >= 0; p--) begin
      if (nv[2*p+2] && (!nv[2*p+1] || (nval[2*p+2] < nval[2*p+1]))) begin
        nv[p]   = nv[2*p+2];
        nval[p] = nval[2*p+2];
        nidx[p] = nidx[2*p+2];
      end else begin
        nv[p]   = nv[2*p+1];
        nval[p] = nval[2*p+1];
        nidx[p] = nidx[2*p+1];
      end
    end
    sel.go       = all_ready && any_buf;
    sel.done     = all_done;
    sel.best     = nidx[0];
    sel.best_val = nval[0];
  end

endmodule

// ===== sv/k_way_merge_sorted_streams_unit.sv =====
// k-way merge top level: request control, per-list bookkeeping and result register.
// Merges up to num_lists ascending streams of signed values into one ascending
// stream. Each request either adds an element to a list or closes it; elements
// sit in a circular buffer per list held in one RAM, with each list's head
// cached in a register. An accepted request is checked in the EXEC state; a
// bad one ends there with an error result, a good one is applied, then each
// emitted element takes a SCAN step, plus a FETCH step when its list still
// holds data (the single RAM read port fetches the next head), and a closing
// SCAN step ends the request. Emission pauses while the result register is
// full. A new request is taken as soon as the previous one has finished, even
// while its last result still waits at the output. num_lists may only be
// written while the unit is idle.
module k_way_merge_sorted_streams_unit import kwm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  nlists_t cfg_data,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    req_type,
  input  list_t   list_id,
  input  value_t  value,
  output logic    out_valid,
  input  logic    out_ready,
  output value_t  out_value,
  output list_t   source_list,
  output logic [1:0] status,
  output logic    last_of_run,
  output logic    merge_done
);

  state_t  state, state_next;
  nlists_t num_lists;
  nlists_t n_eff;

  value_t  heads     [MAX_LISTS];
  cnt_t    counts    [MAX_LISTS];
  slot_t   read_slot [MAX_LISTS];
  logic    closed    [MAX_LISTS];
  logic    active    [MAX_LISTS];

  logic    it_type;
  list_t   it_id;
  value_t  it_value;

  logic    pend_valid;
  value_t  pend_value;
  list_t   pend_src;
  list_t   fetch_id;

  sel_t    sel;
  logic    slot_free;
  logic    item_bad;
  status_t item_err;

  // control strobes
  logic    push;
  value_t  push_value;
  list_t   push_src;
  status_t push_status;
  logic    push_last;
  logic    push_done;
  logic    do_insert;
  logic    do_emit;
  logic    do_finish;
  logic    do_clear;
  logic    rd_en;
  addr_t   rd_addr;
  logic    wr_en;
  addr_t   wr_addr;
  value_t  rd_data;

  kwm_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(BUF_ENTRIES)
  ) u_buf (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(it_value),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  kwm_head_sel u_sel (
    .heads (heads),
    .counts(counts),
    .closed(closed),
    .active(active),
    .sel   (sel)
  );

  always_comb begin
    if (num_lists == '0) n_eff = NL_W'(1);
    else if (num_lists > NL_W'(MAX_LISTS)) n_eff = NL_W'(MAX_LISTS);
    else n_eff = num_lists;
    for (int i = 0; i < MAX_LISTS; i++) begin
      active[i] = NL_W'(i) < n_eff;
    end
  end

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    item_bad = 1'b0;
    item_err = ST_BAD;
    if (NL_W'(it_id) >= n_eff) begin
      item_bad = 1'b1;
    end else if (it_type == REQ_ELEM) begin
      if (closed[it_id]) begin
        item_bad = 1'b1;
      end else if (counts[it_id] >= CNT_W'(BUFFER_DEPTH)) begin
        item_bad = 1'b1;
        item_err = ST_FULL;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!item_bad) state_next = S_SCAN;
        else if (slot_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (sel.go) begin
          if ((!pend_valid || slot_free) && counts[sel.best] > CNT_W'(1)) begin
            state_next = S_FETCH;
          end
        end else if (!(pend_valid || sel.done) || slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: state_next = S_SCAN;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready    = 1'b0;
    push        = 1'b0;
    push_value  = '0;
    push_src    = '0;
    push_status = ST_ELEM;
    push_last   = 1'b0;
    push_done   = 1'b0;
    do_insert   = 1'b0;
    do_emit     = 1'b0;
    do_finish   = 1'b0;
    do_clear    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = buf_addr(sel.best, slot_inc(read_slot[sel.best]));
    wr_en       = 1'b0;
    wr_addr     = buf_addr(it_id, wr_slot(read_slot[it_id], counts[it_id]));
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        if (item_bad) begin
          push        = slot_free;
          push_src    = it_id;
          push_status = item_err;
          push_last   = 1'b1;
        end else begin
          do_insert = 1'b1;
          wr_en     = (it_type == REQ_ELEM);
        end
      end
      S_SCAN: begin
        if (sel.go) begin
          if (!pend_valid || slot_free) begin
            do_emit    = 1'b1;
            push       = pend_valid;
            push_value = pend_value;
            push_src   = pend_src;
            rd_en      = counts[sel.best] > CNT_W'(1);
          end
        end else if (!(pend_valid || sel.done) || slot_free) begin
          do_finish = 1'b1;
          do_clear  = sel.done;
          push      = pend_valid || sel.done;
          push_last = 1'b1;
          push_done = sel.done;
          if (pend_valid) begin
            push_value = pend_value;
            push_src   = pend_src;
          end else begin
            push_status = ST_EMPTY_DONE;
          end
        end
      end
      S_FETCH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      num_lists  <= NL_W'(2);
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      for (int i = 0; i < MAX_LISTS; i++) begin
        counts[i]    <= '0;
        read_slot[i] <= '0;
        closed[i]    <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) num_lists <= cfg_data;

      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (do_insert) begin
        if (it_type == REQ_ELEM) counts[it_id] <= counts[it_id] + 1'b1;
        else closed[it_id] <= 1'b1;
      end

      if (do_emit) begin
        pend_valid           <= 1'b1;
        counts[sel.best]    <= counts[sel.best] - 1'b1;
        read_slot[sel.best] <= slot_inc(read_slot[sel.best]);
      end

      if (do_finish) pend_valid <= 1'b0;

      if (do_clear) begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          counts[i]    <= '0;
          read_slot[i] <= '0;
          closed[i]    <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_type  <= req_type;
      it_id    <= list_id;
      it_value <= value;
    end
    if (push) begin
      out_value   <= push_value;
      source_list <= push_src;
      status      <= push_status;
      last_of_run <= push_last;
      merge_done  <= push_done;
    end
    if (do_emit) begin
      pend_value <= sel.best_val;
      pend_src   <= sel.best;
      fetch_id   <= sel.best;
    end
    // an empty list's first element becomes its head straight away
    if (do_insert && it_type == REQ_ELEM && counts[it_id] == '0) begin
      heads[it_id] <= it_value;
    end
    if (state == S_FETCH) begin
      heads[fetch_id] <= rd_data;
    end
  end

endmodule
